// ===== rtl/lsse_pkg.sv =====
// lsse_pkg: shared types and constants of the lsb stego stream extractor
// no dependencies; imported by every module of the block
`default_nettype none

package lsse_pkg;

  localparam int unsigned ImageByteWidth = 8;
  localparam int unsigned PasswordWidth  = 16;
  localparam int unsigned HeaderLenWidth = 10;
  localparam int unsigned ValueWidth     = 32;
  localparam int unsigned KindWidth      = 3;
  localparam int unsigned BitCountWidth  = 5;
  localparam int unsigned CfgAddrWidth   = 1;
  localparam int unsigned CfgDataWidth   = 16;
  localparam int unsigned MagicBits      = 16;
  localparam int unsigned PayloadBits    = 8;

  localparam logic [HeaderLenWidth-1:0] HeaderLenReset = 10'd54;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_PASSWORD      = 1'b0,
    CFG_HEADER_LENGTH = 1'b1
  } cfg_addr_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_MAGIC,
    PH_EXTLEN,
    PH_EXTBYTES,
    PH_DATALEN,
    PH_DATABYTES
  } phase_e;

  typedef enum logic [KindWidth-1:0] {
    KIND_EXT_LEN   = 3'd0,
    KIND_EXT_BYTE  = 3'd1,
    KIND_DATA_LEN  = 3'd2,
    KIND_DATA_BYTE = 3'd3,
    KIND_MISMATCH  = 3'd4
  } kind_e;

  typedef struct packed {
    logic start;
    logic hidden_bit;
  } in_item_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ValueWidth-1:0] value;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/lsb_stego_stream_extractor.sv =====
// lsb_stego_stream_extractor: top level of the hidden frame extractor
// depends on lsse_pkg, lsse_in_stage, lsse_decoder and lsse_out_stage
`default_nettype none

// Takes one image byte per cycle and returns the frame hidden in the byte
// lsbs: extension length, extension bytes, data length and data bytes, or one
// mismatch result when the magic differs from the password. A result passes
// the input register and the result register on its way to the output.
// Input requests stall only while a result waits in the result register and
// the output side is not ready.
module lsb_stego_stream_extractor
  import lsse_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0]   cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0]   cfg_data_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [ImageByteWidth-1:0] s_axis_tdata,  // image_byte
  input  wire logic                      s_axis_tuser,  // start_of_image
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [ValueWidth-1:0]          m_axis_tdata,  // value
  output logic [KindWidth-1:0]           m_axis_tuser,  // kind
  output logic                           m_axis_tlast
);

  logic     out_free;
  logic     advance;
  in_item_t item;
  logic     res_valid;
  result_t  result;

  lsse_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .out_free_i    (out_free),
    .advance_o     (advance),
    .item_o        (item)
  );

  lsse_decoder #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  lsse_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_valid),
    .result_i      (result),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/lsse_in_stage.sv =====
// lsse_in_stage: input register of the extractor, holds one image byte request
// depends on lsse_pkg; feeds lsse_decoder
`default_nettype none

module lsse_in_stage
  import lsse_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [ImageByteWidth-1:0] s_axis_tdata,
  input  wire logic                      s_axis_tuser,
  input  wire logic                      out_free_i,
  output logic                           advance_o,
  output in_item_t                       item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign advance_o     = valid_q && out_free_i;
  assign s_axis_tready = !valid_q || advance_o;
  assign item_o        = item_q;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.start      <= s_axis_tuser;
      item_q.hidden_bit <= s_axis_tdata[0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsse_decoder.sv =====
// lsse_decoder: configuration registers and frame state, one hidden bit per request
// depends on lsse_pkg; fed by lsse_in_stage, drives lsse_out_stage
`default_nettype none

module lsse_decoder
  import lsse_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  input  wire logic                    advance_i,
  input  in_item_t                     item_i,
  output logic                         res_valid_o,
  output result_t                      result_o
);

  localparam int unsigned GatherWidth = (LENGTH_BITS > MagicBits) ? LENGTH_BITS : MagicBits;
  localparam logic [BitCountWidth-1:0] MagicLastPos   = BitCountWidth'(MagicBits - 1);
  localparam logic [BitCountWidth-1:0] LengthLastPos  = BitCountWidth'(LENGTH_BITS - 1);
  localparam logic [BitCountWidth-1:0] PayloadLastPos = BitCountWidth'(PayloadBits - 1);

  logic [PasswordWidth-1:0]  password_q;
  logic [HeaderLenWidth-1:0] header_length_q;

  phase_e                    phase_q, phase_d, phase_s, phase_eff;
  logic [HeaderLenWidth-1:0] header_count_q, header_count_d, header_count_s;
  logic [BitCountWidth-1:0]  bit_count_q, bit_count_d, bit_count_s;
  logic [GatherWidth-1:0]    gather_q, gather_d, gather_s, gather_take;
  logic [LENGTH_BITS-1:0]    remaining_q, remaining_d, remaining_s, remaining_dec;
  logic                      skip;
  logic [LENGTH_BITS-1:0]    length_word;
  logic [ValueWidth-1:0]     length_value, byte_value;

  // start of image drops the partial frame
  assign phase_s        = item_i.start ? PH_HEADER : phase_q;
  assign header_count_s = item_i.start ? '0 : header_count_q;
  assign bit_count_s    = item_i.start ? '0 : bit_count_q;
  assign gather_s       = item_i.start ? '0 : gather_q;
  assign remaining_s    = item_i.start ? '0 : remaining_q;

  assign skip      = (phase_s == PH_HEADER) && (header_count_s < header_length_q);
  assign phase_eff = (phase_s == PH_HEADER) ? PH_MAGIC : phase_s;

  assign gather_take   = ((bit_count_s == '0) ? '0 : gather_s)
                       | (GatherWidth'(item_i.hidden_bit) << bit_count_s);
  assign remaining_dec = remaining_s - LENGTH_BITS'(1);
  assign length_word   = gather_take[LENGTH_BITS-1:0];
  assign length_value  = ValueWidth'(length_word);
  assign byte_value    = ValueWidth'(gather_take[PayloadBits-1:0]);

  // next frame state
  always_comb begin
    phase_d        = phase_q;
    header_count_d = header_count_q;
    bit_count_d    = bit_count_q;
    gather_d       = gather_q;
    remaining_d    = remaining_q;
    if (advance_i) begin
      phase_d        = phase_s;
      header_count_d = header_count_s;
      bit_count_d    = bit_count_s;
      gather_d       = gather_s;
      remaining_d    = remaining_s;
      if (skip) begin
        header_count_d = header_count_s + HeaderLenWidth'(1);
      end else begin
        phase_d = phase_eff;
        case (phase_eff)
          PH_MAGIC: begin
            gather_d    = gather_take;
            bit_count_d = bit_count_s + BitCountWidth'(1);
            if (bit_count_s == MagicLastPos) begin
              bit_count_d = '0;
              if (gather_take[MagicBits-1:0] != password_q) begin
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_EXTLEN;
              end
            end
          end
          PH_EXTLEN: begin
            gather_d    = gather_take;
            bit_count_d = bit_count_s + BitCountWidth'(1);
            if (bit_count_s == LengthLastPos) begin
              bit_count_d = '0;
              remaining_d = length_word;
              phase_d     = (length_word == '0) ? PH_DATALEN : PH_EXTBYTES;
            end
          end
          PH_EXTBYTES: begin
            gather_d    = gather_take;
            bit_count_d = bit_count_s + BitCountWidth'(1);
            if (bit_count_s == PayloadLastPos) begin
              bit_count_d = '0;
              remaining_d = remaining_dec;
              if (remaining_dec == '0) begin
                phase_d = PH_DATALEN;
              end
            end
          end
          PH_DATALEN: begin
            gather_d    = gather_take;
            bit_count_d = bit_count_s + BitCountWidth'(1);
            if (bit_count_s == LengthLastPos) begin
              bit_count_d = '0;
              remaining_d = length_word;
              if (length_word == '0) begin
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_DATABYTES;
              end
            end
          end
          PH_DATABYTES: begin
            gather_d    = gather_take;
            bit_count_d = bit_count_s + BitCountWidth'(1);
            if (bit_count_s == PayloadLastPos) begin
              bit_count_d = '0;
              remaining_d = remaining_dec;
              if (remaining_dec == '0) begin
                phase_d = PH_IDLE;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // result of the current request
  always_comb begin
    res_valid_o = 1'b0;
    result_o    = '{kind: KIND_EXT_LEN, value: '0, last: 1'b0};
    if (advance_i && !skip) begin
      case (phase_eff)
        PH_MAGIC: begin
          if (bit_count_s == MagicLastPos && gather_take[MagicBits-1:0] != password_q) begin
            res_valid_o = 1'b1;
            result_o    = '{kind: KIND_MISMATCH, value: '0, last: 1'b1};
          end
        end
        PH_EXTLEN: begin
          if (bit_count_s == LengthLastPos) begin
            res_valid_o = 1'b1;
            result_o    = '{kind: KIND_EXT_LEN, value: length_value, last: 1'b0};
          end
        end
        PH_EXTBYTES: begin
          if (bit_count_s == PayloadLastPos) begin
            res_valid_o = 1'b1;
            result_o    = '{kind: KIND_EXT_BYTE, value: byte_value, last: 1'b0};
          end
        end
        PH_DATALEN: begin
          if (bit_count_s == LengthLastPos) begin
            res_valid_o = 1'b1;
            result_o    = '{kind: KIND_DATA_LEN, value: length_value,
                            last: (length_word == '0)};
          end
        end
        PH_DATABYTES: begin
          if (bit_count_s == PayloadLastPos) begin
            res_valid_o = 1'b1;
            result_o    = '{kind: KIND_DATA_BYTE, value: byte_value,
                            last: (remaining_dec == '0)};
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      password_q      <= '0;
      header_length_q <= HeaderLenReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PASSWORD:      password_q      <= cfg_data_i[PasswordWidth-1:0];
        CFG_HEADER_LENGTH: header_length_q <= cfg_data_i[HeaderLenWidth-1:0];
        default:           password_q      <= password_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      header_count_q <= '0;
      bit_count_q    <= '0;
      gather_q       <= '0;
      remaining_q    <= '0;
    end else begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      bit_count_q    <= bit_count_d;
      gather_q       <= gather_d;
      remaining_q    <= remaining_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsse_out_stage.sv =====
// lsse_out_stage: result register holding one decoded request for the output bus
// depends on lsse_pkg; loaded by lsse_decoder
`default_nettype none

module lsse_out_stage
  import lsse_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  result_t                    result_i,
  output logic                       out_free_o,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [ValueWidth-1:0]      m_axis_tdata,
  output logic [KindWidth-1:0]       m_axis_tuser,
  output logic                       m_axis_tlast
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign out_free_o    = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = result_q.value;
  assign m_axis_tuser  = result_q.kind;
  assign m_axis_tlast  = result_q.last;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsse_checker.sv =====
// lsse_checker: port level assertions of the extractor, bound to the top level
// depends on lsse_pkg and lsb_stego_stream_extractor
`default_nettype none

module lsse_checker
  import lsse_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [ValueWidth-1:0] m_axis_tdata,
  input wire logic [KindWidth-1:0]  m_axis_tuser,
  input wire logic                  m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_EXT_LEN || m_axis_tuser == KIND_EXT_BYTE
      || m_axis_tuser == KIND_DATA_LEN || m_axis_tuser == KIND_DATA_BYTE
      || m_axis_tuser == KIND_MISMATCH))
    else $error("unknown result kind");

  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_MISMATCH) |->
      (m_axis_tlast && m_axis_tdata == '0))
    else $error("mismatch result malformed");

  a_ext_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_EXT_LEN || m_axis_tuser == KIND_EXT_BYTE))
      |-> !m_axis_tlast)
    else $error("extension result flagged last");

  a_byte_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_EXT_BYTE || m_axis_tuser == KIND_DATA_BYTE))
      |-> (m_axis_tdata[ValueWidth-1:PayloadBits] == '0))
    else $error("payload byte wider than a byte");

endmodule

bind lsb_stego_stream_extractor lsse_checker u_lsse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/lsb_stego_stream_extractor_tb.sv =====
// lsb_stego_stream_extractor_tb: self-checking testbench that streams carrier bytes
// with hidden frames and checks every decoded field against its own frame decoder
// depends on lsse_pkg and lsb_stego_stream_extractor
`default_nettype none

module lsb_stego_stream_extractor_tb;
  import lsse_pkg::*;

  localparam int unsigned LengthBits   = 32;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned ItemTarget   = 1400;
  localparam int          NoCut        = 32'h7fff_ffff;

  class frame_extract_scoreboard;
    logic [PasswordWidth-1:0]  password;
    logic [HeaderLenWidth-1:0] header_len;
    phase_e                    phase;
    logic [HeaderLenWidth-1:0] header_cnt;
    logic [BitCountWidth-1:0]  bit_cnt;
    logic [ValueWidth-1:0]     gather;
    logic [ValueWidth-1:0]     remaining;
    result_t                   expected_fields[$];
    int                        errors;

    function new();
      password     = '0;
      header_len   = HeaderLenReset;
      phase        = PH_IDLE;
      header_cnt   = '0;
      bit_cnt      = '0;
      gather       = '0;
      remaining    = '0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_addr_e addr, logic [CfgDataWidth-1:0] data);
      if (addr == CFG_PASSWORD) begin
        password = data[PasswordWidth-1:0];
      end else begin
        header_len = data[HeaderLenWidth-1:0];
      end
    endfunction

    function bit take_hidden_bit(logic hidden, int unsigned width);
      if (bit_cnt == 0) begin
        gather = '0;
      end
      gather[bit_cnt] = hidden;
      if (bit_cnt + 1 >= width) begin
        bit_cnt = '0;
        return 1'b1;
      end
      bit_cnt = bit_cnt + 1'b1;
      return 1'b0;
    endfunction

    function void expect_field(kind_e kind, logic [ValueWidth-1:0] value, logic last);
      result_t r;
      r.kind  = kind;
      r.value = value;
      r.last  = last;
      expected_fields.push_back(r);
    endfunction

    function void note_request(logic [ImageByteWidth-1:0] image_byte, logic sof);
      logic hidden;
      hidden = image_byte[0];
      if (sof) begin
        phase      = PH_HEADER;
        header_cnt = '0;
        bit_cnt    = '0;
        gather     = '0;
        remaining  = '0;
      end
      if (phase == PH_HEADER) begin
        if (header_cnt < header_len) begin
          header_cnt = header_cnt + 1'b1;
          return;
        end
        phase = PH_MAGIC;
      end
      case (phase)
        PH_MAGIC: begin
          if (take_hidden_bit(hidden, MagicBits)) begin
            if (gather[MagicBits-1:0] != password) begin
              phase = PH_IDLE;
              expect_field(KIND_MISMATCH, '0, 1'b1);
            end else begin
              phase = PH_EXTLEN;
            end
          end
        end
        PH_EXTLEN: begin
          if (take_hidden_bit(hidden, LengthBits)) begin
            remaining = gather;
            phase = (remaining == 0) ? PH_DATALEN : PH_EXTBYTES;
            expect_field(KIND_EXT_LEN, remaining, 1'b0);
          end
        end
        PH_EXTBYTES: begin
          if (take_hidden_bit(hidden, PayloadBits)) begin
            remaining = remaining - 1;
            if (remaining == 0) begin
              phase = PH_DATALEN;
            end
            expect_field(KIND_EXT_BYTE, {24'd0, gather[7:0]}, 1'b0);
          end
        end
        PH_DATALEN: begin
          if (take_hidden_bit(hidden, LengthBits)) begin
            remaining = gather;
            if (remaining == 0) begin
              phase = PH_IDLE;
              expect_field(KIND_DATA_LEN, '0, 1'b1);
            end else begin
              phase = PH_DATABYTES;
              expect_field(KIND_DATA_LEN, remaining, 1'b0);
            end
          end
        end
        PH_DATABYTES: begin
          if (take_hidden_bit(hidden, PayloadBits)) begin
            remaining = remaining - 1;
            if (remaining == 0) begin
              phase = PH_IDLE;
            end
            expect_field(KIND_DATA_BYTE, {24'd0, gather[7:0]}, remaining == 0);
          end
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
    endfunction

    function void check_field(logic [KindWidth-1:0] kind, logic [ValueWidth-1:0] value,
                              logic last);
      result_t want;
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %h last %b", $time, kind, value, last);
        errors++;
        return;
      end
      want = expected_fields.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: value expected %h actual %h", $time, want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [CfgAddrWidth-1:0]   cfg_addr;
  logic [CfgDataWidth-1:0]   cfg_data;
  logic                      s_valid;
  logic                      s_axis_tready;
  logic [ImageByteWidth-1:0] s_data;
  logic                      s_user;
  logic                      m_axis_tvalid;
  logic                      m_ready;
  logic [ValueWidth-1:0]     m_axis_tdata;
  logic [KindWidth-1:0]      m_axis_tuser;
  logic                      m_axis_tlast;

  frame_extract_scoreboard decoder;
  int unsigned             cycles;
  int                      items_sent;
  int                      hidden_budget;
  int                      quiet_left;
  logic                    sof_next;
  int                      cur_hdr;

  lsb_stego_stream_extractor #(
    .LENGTH_BITS(LengthBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL lsb_stego_stream_extractor");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      decoder.check_field(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // result side backpressure: short stalls, rare long ones, and long stall-free runs
  initial begin
    int hold;
    int r;
    m_ready = 1'b0;
    hold    = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_ready = 1'b1;
          hold    = $urandom_range(0, 5);
        end else if (r < 90) begin
          m_ready = 1'b0;
          hold    = $urandom_range(0, 2);
        end else if (r < 95) begin
          m_ready = 1'b0;
          hold    = $urandom_range(8, 30);
        end else begin
          m_ready = 1'b1;
          hold    = $urandom_range(50, 150);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 120) return 0;
    if (r < 188) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_payload();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // all driving tasks start and end at a falling edge
  task automatic push_byte(input logic [ImageByteWidth-1:0] image_byte, input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = image_byte;
    s_user  = sof;
    do @(posedge clk_i); while (!s_axis_tready);
    decoder.note_request(image_byte, sof);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_hidden(input logic hidden);
    logic [ImageByteWidth-1:0] raw;
    if (hidden_budget == 0) return;
    hidden_budget--;
    raw    = ImageByteWidth'($urandom);
    raw[0] = hidden;
    push_byte(raw, sof_next);
    sof_next = 1'b0;
  endtask

  task automatic push_field(input logic [ValueWidth-1:0] value, input int width);
    for (int i = 0; i < width; i++) begin
      push_hidden(value[i]);
    end
  endtask

  task automatic push_noise(input int count, input bit allow_sof);
    for (int i = 0; i < count; i++) begin
      push_byte(ImageByteWidth'($urandom_range(0, 255)),
                allow_sof && ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic send_body(input logic [15:0] magic, input logic [31:0] ext_len,
                           input int n_ext, input logic [31:0] data_len, input int n_data);
    push_field(ValueWidth'(magic), MagicBits);
    push_field(ext_len, LengthBits);
    repeat (n_ext) push_field(ValueWidth'(pick_payload()), PayloadBits);
    push_field(data_len, LengthBits);
    repeat (n_data) push_field(ValueWidth'(pick_payload()), PayloadBits);
  endtask

  task automatic send_frame(input logic [15:0] magic, input logic [31:0] ext_len,
                            input int n_ext, input logic [31:0] data_len, input int n_data);
    sof_next = 1'b1;
    repeat (cur_hdr) begin
      push_byte(ImageByteWidth'($urandom_range(0, 255)), sof_next);
      sof_next = 1'b0;
    end
    send_body(magic, ext_len, n_ext, data_len, n_data);
  endtask

  task automatic settle();
    s_valid = 1'b0;
    while (decoder.expected_fields.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_addr_e addr, input logic [CfgDataWidth-1:0] data);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(posedge clk_i);
    decoder.set_reg(addr, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic shuffle_config();
    int r;
    settle();
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 9);
      write_reg(CFG_PASSWORD,
                (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff : CfgDataWidth'($urandom));
    end
    if ($urandom_range(0, 1) == 0) begin
      cur_hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 80) : $urandom_range(0, 6);
      write_reg(CFG_HEADER_LENGTH, CfgDataWidth'(cur_hdr));
    end
  endtask

  initial begin
    logic [15:0] bad_magic;
    logic [31:0] ext_len;
    logic [31:0] data_len;
    int          r;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_PASSWORD;
    cfg_data      = '0;
    s_valid       = 1'b0;
    s_data        = '0;
    s_user        = 1'b0;
    cycles        = 0;
    items_sent    = 0;
    quiet_left    = 0;
    sof_next      = 1'b0;
    hidden_budget = NoCut;
    cur_hdr       = int'(HeaderLenReset);
    decoder       = new();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bytes before any start are dropped, then a frame with the reset settings
    push_noise(4, 1'b0);
    send_frame(16'h0000, 32'd0, 0, 32'd1, 1);

    // no header, all-ones password
    settle();
    write_reg(CFG_PASSWORD, 16'hffff);
    cur_hdr = 0;
    write_reg(CFG_HEADER_LENGTH, 16'd0);
    send_frame(16'hffff, 32'd2, 2, 32'd3, 3);
    push_noise(3, 1'b0);

    // magic mismatch, trailing bytes ignored
    sof_next = 1'b1;
    push_field(32'h0000_7fff, MagicBits);
    push_noise(3, 1'b0);

    // zero extension and zero data length
    send_frame(16'hffff, 32'd0, 0, 32'd0, 0);

    // restart in the middle of huge lengths
    hidden_budget = 40;
    send_frame(16'hffff, 32'hffff_ffff, 2, 32'hffff_ffff, 2);
    hidden_budget = MagicBits + 2 * LengthBits + 8;
    send_frame(16'hffff, 32'd0, 0, 32'hffff_ffff, 2);
    hidden_budget = NoCut;
    send_frame(16'hffff, 32'd1, 1, 32'd1, 1);

    // long header
    settle();
    write_reg(CFG_PASSWORD, 16'h0000);
    cur_hdr = 300;
    write_reg(CFG_HEADER_LENGTH, 16'd300);
    send_frame(16'h0000, 32'd1, 1, 32'd1, 1);

    // header length lowered below the count while skipping
    settle();
    write_reg(CFG_HEADER_LENGTH, 16'd20);
    sof_next = 1'b1;
    repeat (12) begin
      push_byte(ImageByteWidth'($urandom_range(0, 255)), sof_next);
      sof_next = 1'b0;
    end
    settle();
    cur_hdr = 5;
    write_reg(CFG_HEADER_LENGTH, 16'd5);
    send_body(16'h0000, 32'd0, 0, 32'd2, 2);

    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 3) == 0) begin
        shuffle_config();
      end
      r = $urandom_range(0, 99);
      if (r < 68) begin
        ext_len  = $urandom_range(0, 3);
        data_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 5);
        send_frame(decoder.password, ext_len, ext_len, data_len, data_len);
        if ($urandom_range(0, 2) == 0) begin
          push_noise($urandom_range(1, 4), 1'b0);
        end
      end else if (r < 78) begin
        bad_magic = decoder.password ^ (16'h1 << $urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) begin
          bad_magic = 16'($urandom);
          if (bad_magic == decoder.password) begin
            bad_magic = ~bad_magic;
          end
        end
        send_frame(bad_magic, 32'd0, 0, 32'd0, 0);
      end else if (r < 90) begin
        ext_len       = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
        data_len      = $urandom;
        hidden_budget = $urandom_range(0, 120);
        send_frame(decoder.password, ext_len, 2, data_len, 2);
        hidden_budget = NoCut;
      end else begin
        push_noise($urandom_range(5, 30), 1'b1);
      end
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (decoder.errors == 0 && decoder.expected_fields.size() == 0) begin
      $display("PASS lsb_stego_stream_extractor");
    end else begin
      if (decoder.expected_fields.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time,
                 decoder.expected_fields.size());
      end
      $display("FAIL lsb_stego_stream_extractor");
    end
    $finish;
  end

endmodule

`default_nettype wire
